// File: sv/etok_pkg.sv
`timescale 1ns / 1ps

package etok_pkg;

	// default depth of the queue between lexer and emitter
	localparam int FIFO_DEPTH = 4;

	// event kinds
	localparam logic [1:0] EV_APPEND = 2'd0;
	localparam logic [1:0] EV_CLOSE  = 2'd1;
	localparam logic [1:0] EV_SINGLE = 2'd2;
	localparam logic [1:0] EV_ERROR  = 2'd3;

	// token types
	localparam logic [2:0] TT_NONE     = 3'd0;
	localparam logic [2:0] TT_OP       = 3'd0;
	localparam logic [2:0] TT_LPAREN   = 3'd1;
	localparam logic [2:0] TT_RPAREN   = 3'd2;
	localparam logic [2:0] TT_NUMBER   = 3'd3;
	localparam logic [2:0] TT_FUNCTION = 3'd4;
	localparam logic [2:0] TT_SEP      = 3'd5;
	localparam logic [2:0] TT_VARIABLE = 3'd6;

	// associativity
	localparam logic [1:0] AS_NONE  = 2'd0;
	localparam logic [1:0] AS_LEFT  = 2'd1;
	localparam logic [1:0] AS_RIGHT = 2'd2;

	// error codes
	localparam logic [1:0] ER_NONE       = 2'd0;
	localparam logic [1:0] ER_UNKNOWN    = 2'd1;
	localparam logic [1:0] ER_UNEXPECTED = 2'd2;

	// characters
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5A;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LZ     = 8'h7A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_POINT  = 8'h2E;
	localparam logic [7:0] CH_COMMA  = 8'h2C;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_expr;
	} in_item_t;

	typedef struct packed {
		logic [1:0] event_kind;
		logic [7:0] char_out;
		logic [2:0] token_type;
		logic [1:0] assoc;
		logic [1:0] error_code;
		logic       last_of_run;
	} out_item_t;

	// one queue entry: all events caused by one character (one or two)
	typedef struct packed {
		logic                dual;
		out_item_t [1:0]     res;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

// File: sv/etok_front.sv
`timescale 1ns / 1ps

module etok_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                char_valid,
	output logic                char_stall,
	input  etok_pkg::in_item_t  char_item,
	input  etok_pkg::fifo_stat_t stat,
	output logic                push,
	output etok_pkg::entry_t    push_data
);
	import etok_pkg::*;

	typedef enum logic [5:0] {
		ST_START  = 6'b000001,
		ST_SINGLE = 6'b000010,
		ST_INT    = 6'b000100,
		ST_FRAC   = 6'b001000,
		ST_IDENT  = 6'b010000,
		ST_CLOSED = 6'b100000
	} lex_state_t;

	lex_state_t state_q, nxt;
	logic [2:0] open_type_q, otype_nx;
	logic       seen_q, prev_lp_q, hold_q;

	logic [7:0] ch;
	logic       take, bad;
	logic       is_dig, is_let, is_lp, is_rp, is_par, is_pt, is_sep, is_op, is_known;
	logic [2:0] sgl_type;
	logic [1:0] sgl_assoc;

	function automatic out_item_t mk(input logic [1:0] kind, input logic [7:0] c,
			input logic [2:0] tt, input logic [1:0] as, input logic [1:0] err,
			input logic last);
		out_item_t r;
		r.event_kind  = kind;
		r.char_out    = c;
		r.token_type  = tt;
		r.assoc       = as;
		r.error_code  = err;
		r.last_of_run = last;
		return r;
	endfunction

	assign ch         = char_item.ch;
	assign char_stall = stat.full;
	assign take       = char_valid && !char_stall;
	assign push       = take && !hold_q;

	assign is_dig   = ch inside {[CH_0:CH_9]};
	assign is_let   = ch inside {[CH_UA:CH_UZ], [CH_LA:CH_LZ]};
	assign is_lp    = ch == CH_LPAREN;
	assign is_rp    = ch == CH_RPAREN;
	assign is_par   = is_lp || is_rp;
	assign is_pt    = ch == CH_POINT;
	assign is_sep   = ch == CH_COMMA;
	assign is_op    = ch inside {CH_PLUS, CH_MINUS, CH_STAR, CH_CARET, CH_SLASH};
	assign is_known = is_dig || is_let || is_par || is_pt || is_sep || is_op;

	always_comb begin
		nxt      = state_q;
		bad      = 1'b0;
		otype_nx = open_type_q;
		case (state_q)
			ST_START, ST_CLOSED, ST_SINGLE: begin
				if (is_par || (is_op && state_q != ST_SINGLE)) begin
					nxt = ST_SINGLE;
				end else if (is_dig) begin
					nxt      = ST_INT;
					otype_nx = TT_NUMBER;
				end else if (is_let) begin
					nxt      = ST_IDENT;
					otype_nx = TT_VARIABLE;
				end else begin
					bad = 1'b1;
				end
			end
			ST_INT: begin
				if (is_dig) begin
					nxt = ST_INT;
				end else if (is_pt) begin
					nxt = ST_FRAC;
				end else if (is_par || is_op || is_sep) begin
					nxt = ST_CLOSED;
				end else begin
					bad = 1'b1;
				end
			end
			ST_FRAC: begin
				if (is_dig) begin
					nxt = ST_FRAC;
				end else if (is_par || is_op || is_sep) begin
					nxt = ST_CLOSED;
				end else begin
					bad = 1'b1;
				end
			end
			default: begin
				// identifier
				otype_nx = TT_VARIABLE;
				if (is_lp) begin
					nxt      = ST_CLOSED;
					otype_nx = TT_FUNCTION;
				end else if (is_op || is_sep || is_rp) begin
					nxt = ST_CLOSED;
				end else if (is_pt) begin
					bad = 1'b1;
				end else begin
					nxt = ST_IDENT;
				end
			end
		endcase
	end

	always_comb begin
		if (is_op) begin
			sgl_type = TT_OP;
		end else if (is_lp) begin
			sgl_type = TT_LPAREN;
		end else if (is_rp) begin
			sgl_type = TT_RPAREN;
		end else begin
			sgl_type = TT_SEP;
		end
		// right-assoc when first token or right after '('
		sgl_assoc = is_op ? ((!seen_q || prev_lp_q) ? AS_RIGHT : AS_LEFT) : AS_NONE;
	end

	always_comb begin
		push_data = '0;
		if (!is_known) begin
			push_data.res[0] = mk(EV_ERROR, ch, TT_NONE, AS_NONE, ER_UNKNOWN, 1'b1);
		end else if (bad) begin
			push_data.res[0] = mk(EV_ERROR, ch, TT_NONE, AS_NONE, ER_UNEXPECTED, 1'b1);
		end else if (nxt == ST_SINGLE) begin
			push_data.res[0] = mk(EV_SINGLE, ch, sgl_type, sgl_assoc, ER_NONE, 1'b1);
		end else if (nxt == ST_CLOSED) begin
			// the close just made a token, so an operator here is left-assoc
			push_data.dual   = 1'b1;
			push_data.res[0] = mk(EV_CLOSE, 8'h00, otype_nx, AS_NONE, ER_NONE, 1'b0);
			push_data.res[1] = mk(EV_SINGLE, ch, sgl_type, is_op ? AS_LEFT : AS_NONE,
					ER_NONE, 1'b1);
		end else begin
			push_data.dual   = char_item.end_of_expr;
			push_data.res[0] = mk(EV_APPEND, ch, TT_NONE, AS_NONE, ER_NONE,
					!char_item.end_of_expr);
			push_data.res[1] = mk(EV_CLOSE, 8'h00, otype_nx, AS_NONE, ER_NONE, 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_START;
			open_type_q <= TT_VARIABLE;
			seen_q      <= 1'b0;
			prev_lp_q   <= 1'b0;
			hold_q      <= 1'b0;
		end else if (take) begin
			if (char_item.end_of_expr) begin
				state_q     <= ST_START;
				open_type_q <= TT_VARIABLE;
				seen_q      <= 1'b0;
				prev_lp_q   <= 1'b0;
				hold_q      <= 1'b0;
			end else if (!hold_q) begin
				if (is_known) begin
					open_type_q <= otype_nx;
				end
				if (!is_known || bad) begin
					hold_q <= 1'b1;
				end else begin
					state_q <= nxt;
					if (nxt == ST_SINGLE || nxt == ST_CLOSED) begin
						seen_q    <= 1'b1;
						prev_lp_q <= is_lp;
					end
				end
			end
		end
	end

endmodule

// File: sv/etok_fifo.sv
`timescale 1ns / 1ps

module etok_fifo #(
	parameter int DEPTH = etok_pkg::FIFO_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  etok_pkg::entry_t     push_data,
	input  logic                 pop,
	output etok_pkg::entry_t     head,
	output etok_pkg::fifo_stat_t stat
);
	import etok_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t          mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;

	function automatic logic [AW-1:0] adv(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = count_q == CW'(DEPTH);
	assign stat.empty = count_q == '0;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= adv(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= adv(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full) else $error("etok_fifo: push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty) else $error("etok_fifo: pop while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("etok_fifo: count beyond depth");

endmodule

// File: sv/etok_back.sv
`timescale 1ns / 1ps

module etok_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  etok_pkg::entry_t     head,
	input  etok_pkg::fifo_stat_t stat,
	output logic                 pop,
	output logic                 event_valid,
	input  logic                 event_stall,
	output etok_pkg::out_item_t  event_item
);
	import etok_pkg::*;

	out_item_t out_q;
	logic      out_valid_q;
	logic      sel_q;
	logic      open, load;

	assign open        = !out_valid_q || !event_stall;
	assign load        = open && !stat.empty;
	// entry leaves once its last event is loaded
	assign pop         = load && (sel_q || !head.dual);
	assign event_valid = out_valid_q;
	assign event_item  = out_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= head.res[sel_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sel_q       <= 1'b0;
		end else begin
			if (open) begin
				out_valid_q <= !stat.empty;
			end
			if (load) begin
				sel_q <= !pop;
			end
		end
	end

	a_sel_pending: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> !stat.empty) else $error("etok_back: second event without entry");
	a_sel_first: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> (out_valid_q && !out_q.last_of_run))
		else $error("etok_back: first of two events marked last");

endmodule

// File: sv/expression_char_tokenizer.sv
`timescale 1ns / 1ps

// channel  | dir | handshake                 | payload
// ---------+-----+---------------------------+---------------------------------
// char     | in  | char_valid / char_stall   | char_item  (etok_pkg::in_item_t)
// event    | out | event_valid / event_stall | event_item (etok_pkg::out_item_t)
//
// One character is taken per cycle while char_stall is low; the lexer state updates
// at the accepting edge. Events leave one per cycle from the output register while
// event_stall is low, a character's two events in turn; FIFO_DEPTH entries absorb bursts.
// char_stall is high only while the queue is full; event_stall holds the output.
// Reset clears lexer state, queue pointers and output valid; no clearing pass.
// An error character yields one event, then nothing until the end-of-expression item.

module expression_char_tokenizer #(
	parameter int FIFO_DEPTH = etok_pkg::FIFO_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                char_valid,
	output logic                char_stall,
	input  etok_pkg::in_item_t  char_item,
	output logic                event_valid,
	input  logic                event_stall,
	output etok_pkg::out_item_t event_item
);
	import etok_pkg::*;

	logic       push, pop;
	entry_t     push_data, head;
	fifo_stat_t stat;

	etok_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_item  (char_item),
		.stat       (stat),
		.push       (push),
		.push_data  (push_data)
	);

	etok_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (stat)
	);

	etok_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.stat        (stat),
		.pop         (pop),
		.event_valid (event_valid),
		.event_stall (event_stall),
		.event_item  (event_item)
	);

endmodule

// File: verif/expression_char_tokenizer_tb.sv
`timescale 1ns / 1ps

module expression_char_tokenizer_tb;
	import etok_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 8;

	typedef enum logic [2:0] {
		LX_START, LX_SINGLE, LX_INT, LX_FRAC, LX_IDENT, LX_CLOSED
	} lex_st_t;

	localparam logic [7:0] OP_CHARS [5] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_CARET, CH_SLASH};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic char_valid = 1'b0;
	logic char_stall;
	in_item_t char_item = '0;
	logic event_valid;
	logic event_stall = 1'b0;
	out_item_t event_item;

	// lexer model state
	lex_st_t lx_state = LX_START;
	logic [2:0] lx_open_type = TT_VARIABLE;
	bit lx_any_token = 0;
	bit lx_after_lparen = 0;
	bit lx_error_hold = 0;

	out_item_t pending_events [$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_cycles = 0;
	int quiet_cycles = 0;

	expression_char_tokenizer uut (.*);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic out_item_t make_event(logic [1:0] kind, logic [7:0] c, logic [2:0] ttype,
			logic [1:0] asc, logic [1:0] err);
		out_item_t ev;
		ev.event_kind = kind;
		ev.char_out = c;
		ev.token_type = ttype;
		ev.assoc = asc;
		ev.error_code = err;
		ev.last_of_run = 1'b0;
		return ev;
	endfunction

	function automatic out_item_t single_token(logic [7:0] c, bit op, bit lp, bit rp);
		logic [2:0] ttype;
		logic [1:0] asc;
		ttype = TT_SEP;
		asc = AS_NONE;
		if (op) begin
			ttype = TT_OP;
			asc = (!lx_any_token || lx_after_lparen) ? AS_RIGHT : AS_LEFT;
		end else if (lp) begin
			ttype = TT_LPAREN;
		end else if (rp) begin
			ttype = TT_RPAREN;
		end
		lx_any_token = 1;
		lx_after_lparen = lp;
		return make_event(EV_SINGLE, c, ttype, asc, ER_NONE);
	endfunction

	function automatic out_item_t close_token();
		lx_any_token = 1;
		lx_after_lparen = 0;
		return make_event(EV_CLOSE, 8'h00, lx_open_type, AS_NONE, ER_NONE);
	endfunction

	// advance the lexer model by one character, queue the events it causes
	function automatic void lex_char(logic [7:0] c, logic eoe);
		out_item_t step_ev [2];
		int n;
		bit dig, alpha, lp, rp, par, pt, sep, op, bad;
		lex_st_t nxt;
		n = 0;
		if (!lx_error_hold) begin
			dig = c >= CH_0 && c <= CH_9;
			alpha = (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
			lp = c == CH_LPAREN;
			rp = c == CH_RPAREN;
			par = lp || rp;
			pt = c == CH_POINT;
			sep = c == CH_COMMA;
			op = c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_CARET || c == CH_SLASH;
			bad = 0;
			nxt = lx_state;
			if (!(dig || alpha || par || pt || sep || op)) begin
				step_ev[0] = make_event(EV_ERROR, c, TT_NONE, AS_NONE, ER_UNKNOWN);
				n = 1;
				lx_error_hold = 1;
			end else begin
				case (lx_state)
					LX_START, LX_CLOSED, LX_SINGLE: begin
						if (par || (op && lx_state != LX_SINGLE)) begin
							nxt = LX_SINGLE;
						end else if (dig) begin
							nxt = LX_INT;
							lx_open_type = TT_NUMBER;
						end else if (alpha) begin
							nxt = LX_IDENT;
							lx_open_type = TT_VARIABLE;
						end else begin
							bad = 1;
						end
					end
					LX_INT: begin
						if (dig) nxt = LX_INT;
						else if (pt) nxt = LX_FRAC;
						else if (par || op || sep) nxt = LX_CLOSED;
						else bad = 1;
					end
					LX_FRAC: begin
						if (dig) nxt = LX_FRAC;
						else if (par || op || sep) nxt = LX_CLOSED;
						else bad = 1;
					end
					default: begin
						lx_open_type = TT_VARIABLE;
						if (lp) begin
							nxt = LX_CLOSED;
							lx_open_type = TT_FUNCTION;
						end else if (op || sep || rp) begin
							nxt = LX_CLOSED;
						end else if (pt) begin
							bad = 1;
						end else begin
							nxt = LX_IDENT;
						end
					end
				endcase
				if (bad) begin
					step_ev[0] = make_event(EV_ERROR, c, TT_NONE, AS_NONE, ER_UNEXPECTED);
					n = 1;
					lx_error_hold = 1;
				end else begin
					lx_state = nxt;
					if (nxt == LX_SINGLE) begin
						step_ev[0] = single_token(c, op, lp, rp);
						n = 1;
					end else if (nxt == LX_CLOSED) begin
						step_ev[0] = close_token();
						step_ev[1] = single_token(c, op, lp, rp);
						n = 2;
					end else begin
						step_ev[0] = make_event(EV_APPEND, c, TT_NONE, AS_NONE, ER_NONE);
						n = 1;
					end
					// final character flushes the open token
					if (eoe && (nxt == LX_INT || nxt == LX_FRAC || nxt == LX_IDENT)) begin
						step_ev[1] = close_token();
						n = 2;
					end
				end
			end
		end
		if (n > 0) step_ev[n - 1].last_of_run = 1'b1;
		for (int i = 0; i < n; i++) pending_events.insert(pending_events.size(), step_ev[i]);
		if (eoe) begin
			lx_state = LX_START;
			lx_open_type = TT_VARIABLE;
			lx_any_token = 0;
			lx_after_lparen = 0;
			lx_error_hold = 0;
		end
	endfunction

	function automatic logic [7:0] digit_char();
		return CH_0 + 8'($urandom_range(9));
	endfunction

	function automatic logic [7:0] letter_char();
		return ($urandom_range(1) ? CH_UA : CH_LA) + 8'($urandom_range(25));
	endfunction

	function automatic logic [7:0] op_char();
		return OP_CHARS[$urandom_range(4)];
	endfunction

	function automatic logic [7:0] paren_char();
		return $urandom_range(1) ? CH_LPAREN : CH_RPAREN;
	endfunction

	// mostly a character the current lexer state accepts, sometimes noise
	function automatic logic [7:0] next_char();
		int r;
		r = $urandom_range(99);
		if (r < 4) return 8'($urandom_range(255));
		if (r < 8) begin
			case ($urandom_range(3))
				0: return op_char();
				1: return paren_char();
				2: return CH_POINT;
				default: return CH_COMMA;
			endcase
		end
		case (lx_state)
			LX_START, LX_CLOSED: begin
				case ($urandom_range(5))
					0, 1: return digit_char();
					2: return letter_char();
					3: return CH_LPAREN;
					4: return CH_RPAREN;
					default: return op_char();
				endcase
			end
			LX_SINGLE: begin
				case ($urandom_range(5))
					0, 1: return digit_char();
					2, 3: return letter_char();
					4: return CH_LPAREN;
					default: return CH_RPAREN;
				endcase
			end
			LX_INT: begin
				case ($urandom_range(5))
					0, 1: return digit_char();
					2: return CH_POINT;
					3: return op_char();
					4: return paren_char();
					default: return CH_COMMA;
				endcase
			end
			LX_FRAC: begin
				case ($urandom_range(4))
					0, 1: return digit_char();
					2: return op_char();
					3: return paren_char();
					default: return CH_COMMA;
				endcase
			end
			default: begin
				case ($urandom_range(5))
					0: return letter_char();
					1: return digit_char();
					2: return CH_LPAREN;
					3: return op_char();
					4: return CH_COMMA;
					default: return CH_RPAREN;
				endcase
			end
		endcase
	endfunction

	task automatic send_char(input logic [7:0] c, input logic eoe);
		while ($urandom_range(99) < send_idle_pct) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_item <= '{ch: c, end_of_expr: eoe};
		do @(posedge clk); while (char_stall);
		lex_char(c, eoe);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
	endtask

	// sender holds off until every queued event has come out
	task automatic drain_events();
		char_valid <= 1'b0;
		@(posedge clk);
		while (pending_events.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic test_directed();
		send_text("a(-1.5,Z9)*2");
		send_text("x/3^+");
		send_char(8'h00, 1'b0);
		send_char(CH_LA, 1'b1);
		send_char(8'hFF, 1'b1);
		send_text("1..");
		send_text("++");
		drain_events();
	endtask

	task automatic test_random(input int count, input int s_pct, input int r_pct);
		int sent;
		bit live;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		sent = 0;
		while (sent < count) begin
			live = !lx_error_hold;
			send_char(next_char(), $urandom_range(99) < (live ? 10 : 40));
			if (live) sent++;
		end
		drain_events();
	endtask

	// receiver stops for a long stretch while characters keep coming
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_cycles = HOLD_CYCLES;
		repeat (40) send_char(next_char(), $urandom_range(9) == 0);
		drain_events();
	endtask

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			event_stall <= 1'b1;
			hold_cycles--;
		end else begin
			event_stall <= $urandom_range(99) < recv_idle_pct;
		end
	end

	task automatic check_field(input string fname, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && event_valid && !event_stall) begin
			if (pending_events.size() == 0) begin
				$display("%0t: unexpected event, expected none, actual %p", $time, event_item);
				mismatches++;
			end else begin
				want = pending_events.pop_front();
				check_field("event_kind", 8'(want.event_kind), 8'(event_item.event_kind));
				check_field("char_out", want.char_out, event_item.char_out);
				check_field("token_type", 8'(want.token_type), 8'(event_item.token_type));
				check_field("assoc", 8'(want.assoc), 8'(event_item.assoc));
				check_field("error_code", 8'(want.error_code), 8'(event_item.error_code));
				check_field("last_of_run", 8'(want.last_of_run),
						8'(event_item.last_of_run));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((char_valid && !char_stall) || (event_valid && !event_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= IDLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(230, 10, 54);
		test_random(230, 54, 10);
		test_backpressure();
		test_random(220, 0, 0);
		mismatches += pending_events.size();
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
